[hdl/sha2s_pkg.sv]
package sha2s_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] SEED [8] = '{
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef struct packed {
    logic       load;   // copy chain into working words
    logic       step;   // run one round
    logic [5:0] rnd;
  } round_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hdl/sha2s_round.sv]
module sha2s_round
  import sha2s_pkg::*;
(
  input  logic        clk,
  input  round_ctl_t  ctl,
  input  logic [31:0] blk_word,
  input  logic [31:0] chain [8],
  output logic [31:0] work [8]
);

  logic [31:0] sched [16];
  logic [31:0] w, s0, s1, w2, w15, t1, t2;
  logic [3:0]  idx;

  assign idx = ctl.rnd[3:0];
  assign w2  = sched[idx - 4'd2];
  assign w15 = sched[idx - 4'd15];
  assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);

  always_comb begin
    if (ctl.rnd < 6'd16) begin
      w = blk_word;
    end else begin
      w = s1 + sched[idx - 4'd7] + s0 + sched[idx];
    end
    t1 = work[7] + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25))
       + (work[6] ^ (work[4] & (work[5] ^ work[6]))) + ROUND_K[ctl.rnd] + w;
    t2 = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22))
       + ((work[0] & work[1]) | (work[2] & (work[0] | work[1])));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= chain;
    end else if (ctl.step) begin
      sched[idx] <= w;
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

endmodule

[hdl/sha2_256_stream_hasher_core.sv]
// SHA-256 byte-stream hasher seeded with the SHA-224 initial values. One byte
// is taken per transfer; the transfer that fills a 64-byte block starts a
// compression (load, 64 rounds through one shared round unit, chain add)
// during which s_tready is low. A final transfer pads the block at one byte
// per cycle, may need a second compression, and then emits the eight digest
// words on the master side, word 0 first.
module sha2_256_stream_hasher_core
  import sha2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte
  input  logic [1:0]  s_tuser,  // has_byte, end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // digest_word
  output logic        m_tlast   // last_word
);

  state_t          state, state_next;
  logic [3:0][7:0] buffer [16];
  logic [63:0]     count;
  logic [5:0]      pos, rnd, fill_pos;
  logic            fin, final_blk, pad_done, blk_full;
  logic [2:0]      wsel;
  logic [31:0]     chain [8];
  logic [31:0]     work [8];
  logic [31:0]     blk_word;
  logic [63:0]     bits;
  logic            take, len_zone;
  logic            we_a, we_b;
  logic [5:0]      addr_a, addr_b;
  logic [7:0]      data_a, data_b;
  round_ctl_t      ctl;

  assign take = s_tvalid && s_tready;
  assign bits = count << 3;
  assign len_zone = final_blk && (pos >= LEN_POS);
  assign fill_pos = count[5:0] + 6'(s_tuser[0]);
  assign blk_full = s_tuser[0] && (count[5:0] == 6'h3F);
  // byte 4i sits in the top lane of word i
  assign blk_word = buffer[rnd[3:0]];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (blk_full || (s_tuser[1] && fill_pos == 6'h3F)) state_next = ST_LOAD;
          else if (s_tuser[1]) state_next = ST_PAD;
        end
      end
      ST_PAD:   if (pos == 6'h3F) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'h3F) state_next = ST_ADD;
      ST_ADD: begin
        if (!fin) state_next = ST_IDLE;
        else if (final_blk) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT:  if (m_tready && wsel == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_EMIT);
    m_tdata  = chain[wsel];
    m_tlast  = (wsel == 3'd7);
    ctl.load = (state == ST_LOAD);
    ctl.step = (state == ST_ROUND);
    ctl.rnd  = rnd;
  end

  // block buffer write ports: message or pad/length byte, plus the early pad byte
  always_comb begin
    we_a   = 1'b0;
    addr_a = pos;
    data_a = '0;
    we_b   = 1'b0;
    addr_b = fill_pos;
    data_b = PAD_BYTE;
    case (state)
      ST_IDLE: begin
        we_a   = take && s_tuser[0];
        addr_a = count[5:0];
        data_a = s_tdata;
        we_b   = take && s_tuser[1] && !blk_full;
      end
      ST_PAD: begin
        we_a   = 1'b1;
        data_a = len_zone ? bits[{~pos[2:0], 3'd0} +: 8] : 8'h00;
      end
      ST_ADD: begin
        we_a   = fin && !final_blk && !pad_done;
        addr_a = '0;
        data_a = PAD_BYTE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 64; j++) begin
      if (we_a && addr_a == 6'(j)) begin
        buffer[j[5:2]][~j[1:0]] <= data_a;
      end else if (we_b && addr_b == 6'(j)) begin
        buffer[j[5:2]][~j[1:0]] <= data_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pos <= '0;
      rnd <= '0;
      fin <= 1'b0;
      final_blk <= 1'b0;
      pad_done <= 1'b0;
      wsel <= '0;
      chain <= SEED;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            fin <= s_tuser[1];
            if (s_tuser[0]) begin
              count <= count + 64'd1;
            end
            if (s_tuser[1] && !blk_full) begin
              // place the pad byte now; the rest follows in ST_PAD
              pos <= fill_pos + 6'd1;
              final_blk <= fill_pos < LEN_POS;
              pad_done <= 1'b1;
            end else begin
              pos <= fill_pos;
              pad_done <= 1'b0;
            end
          end
        end
        ST_PAD:   pos <= pos + 6'd1;
        ST_LOAD:  rnd <= '0;
        ST_ROUND: rnd <= rnd + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
          if (fin && !final_blk) begin
            // block filled by the last byte or overflowed the pad
            pos <= pad_done ? 6'd0 : 6'd1;
            pad_done <= 1'b1;
            final_blk <= 1'b1;
          end
          wsel <= '0;
        end
        ST_EMIT: begin
          if (m_tready) begin
            wsel <= wsel + 3'd1;
            if (wsel == 3'd7) begin
              chain <= SEED;
              count <= '0;
              fin <= 1'b0;
              final_blk <= 1'b0;
              pad_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  sha2s_round u_round (
    .clk      (clk),
    .ctl      (ctl),
    .blk_word (blk_word),
    .chain    (chain),
    .work     (work)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import sha2s_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte
  logic [1:0]  s_tuser;   // has_byte, end_of_message
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // digest_word
  logic        m_tlast;   // last_word

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam int CYCLE_LIMIT = 2000000;

  // hasher state mirrored on the bench side
  logic [31:0] hash_chain [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bytes;

  digest_word_t digest_q[$];
  int  error_count;
  bit  timed_out;
  bit  hold_sink;
  longint cycle_count;

  sha2_256_stream_hasher_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] sched [16];
    logic [31:0] wa, wb, wc, wd, we, wf, wg, wh, w, w2, w15, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    {wa, wb, wc, wd} = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3]};
    {we, wf, wg, wh} = {hash_chain[4], hash_chain[5], hash_chain[6], hash_chain[7]};
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        w2 = sched[(t - 2) & 15];
        w15 = sched[(t - 15) & 15];
        w = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + sched[(t - 7) & 15] +
            (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + sched[t & 15];
        sched[t & 15] = w;
      end
      t1 = wh + (ror32(we, 6) ^ ror32(we, 11) ^ ror32(we, 25)) + (wg ^ (we & (wf ^ wg))) +
           ROUND_K[t] + w;
      t2 = (ror32(wa, 2) ^ ror32(wa, 13) ^ ror32(wa, 22)) + ((wa & wb) | (wc & (wa | wb)));
      wh = wg; wg = wf; wf = we; we = wd + t1;
      wd = wc; wc = wb; wb = wa; wa = t1 + t2;
    end
    hash_chain[0] += wa; hash_chain[1] += wb; hash_chain[2] += wc; hash_chain[3] += wd;
    hash_chain[4] += we; hash_chain[5] += wf; hash_chain[6] += wg; hash_chain[7] += wh;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_chain[i] = SEED[i];
    msg_bytes = '0;
  endtask

  task automatic hash_item(logic [7:0] data, bit has_byte, bit eom);
    logic [63:0] bit_len;
    int pos;
    if (has_byte) begin
      msg_block[msg_bytes[5:0]] = data;
      msg_bytes++;
      if (msg_bytes[5:0] == 0) compress_msg_block();
    end
    if (!eom) return;
    bit_len = msg_bytes << 3;
    pos = int'(msg_bytes[5:0]);
    msg_block[pos++] = PAD_BYTE;
    if (pos > 56) begin
      while (pos < 64) msg_block[pos++] = 8'h00;
      compress_msg_block();
      pos = 0;
    end
    while (pos < 56) msg_block[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) digest_q.push_back('{word: hash_chain[i], last: (i == 7)});
    restart_hash();
  endtask

  // random gap before the transfer unless no_gap is set, held valid until accepted;
  // valid stays high into a following transfer with no gap
  task automatic send_item(logic [7:0] data, bit has_byte, bit eom, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {eom, has_byte};
    hash_item(data, has_byte, eom);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message(int len, bit empty_final, bit no_gap = 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0, no_gap);
      if (i == len - 1 && !empty_final) send_item(8'($urandom), 1'b1, 1'b1, no_gap);
      else send_item(8'($urandom), 1'b1, 1'b0, no_gap);
    end
    if (empty_final || len == 0) send_item(8'($urandom), 1'b0, 1'b1, no_gap);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);           // empty message
    send_item(8'hFF, 1'b0, 1'b0);           // no byte, no end
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);           // empty final after bytes
  endtask

  task automatic test_padding_boundaries();
    // lengths around the length field and the block edge
    int lens [5] = '{55, 56, 63, 64, 65};
    foreach (lens[i]) send_message(lens[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    sent = 0;
    while (sent < 30) begin
      len = $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 3) == 0);
      sent += len + 1;
    end
  endtask

  task automatic test_sink_hold();
    hold_sink = 1'b1;
    send_message(3, 1'b0, 1'b1);
    send_message(8, 1'b0, 1'b1);
    hold_sink = 1'b0;
  endtask

  // sink side: random ready, long hold while hold_sink is set
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        wait_cycles = 0;
        while (hold_sink && wait_cycles < 400) begin
          @(posedge clk);
          wait_cycles++;
        end
      end
      wait_cycles = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h last %b", $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        exp_w = digest_q.pop_front();
        if (m_tdata !== exp_w.word || m_tlast !== exp_w.last) begin
          $display("%0t: digest mismatch expected %h/%b actual %h/%b", $time,
                   exp_w.word, exp_w.last, m_tdata, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    error_count = 0;
    hold_sink = 1'b0;
    timed_out = 1'b0;
    cycle_count = 0;
    restart_hash();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_padding_boundaries();
    test_sink_hold();
    test_random_messages();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
hdl/sha2s_pkg.sv
hdl/sha2s_round.sv
hdl/sha2_256_stream_hasher_core.sv
bench/testbench.sv
